// ===== design/three_axis_offset_quadratic_release_defines.svh =====
// Assertion macros shared by the offset block.
// Define ASSERT_OFF to compile the checks out.
`ifndef THREE_AXIS_OFFSET_QUADRATIC_RELEASE_DEFINES_SVH
`define THREE_AXIS_OFFSET_QUADRATIC_RELEASE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TOQR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("toqr: property check failed");
`define TOQR_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("toqr: forbidden condition seen");
`else
`define TOQR_ASSERT(lbl, clk, rst_n, prop)
`define TOQR_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== design/toqr_pkg.sv =====
`default_nettype none

package toqr_pkg;

    localparam int ANGLE_FRAC_BITS   = 8;
    localparam int FALLOFF_FRAC_BITS = 16;

    localparam int CMD_W     = 2;
    localparam int ANGLE_W   = 17;
    localparam int ROLL_W    = 18;
    localparam int DELTA_W   = 17;
    localparam int DUR_W     = 24;
    localparam int EPS_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int N_AXES    = 3;

    // Q format of alpha and of the falloff factor: one integer bit on top.
    localparam int Q_W     = FALLOFF_FRAC_BITS + 1;
    localparam int MCAND_W = (Q_W > ANGLE_W) ? Q_W : ANGLE_W;
    localparam int PROD_W  = MCAND_W + Q_W;

    localparam logic [Q_W-1:0] ALPHA_ONE = {1'b1, {FALLOFF_FRAC_BITS{1'b0}}};

    // Wrapping of pitch and yaw into (-half, half].
    localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
    localparam int WRAP_W    = ((ANGLE_W + 2) > ($clog2(FULL_TURN) + 2)) ?
                               (ANGLE_W + 2) : ($clog2(FULL_TURN) + 2);
    localparam int FOLDS     = (1 << ANGLE_W) / FULL_TURN + 1;
    localparam int FOLD_CNT_W = $clog2(FOLDS + 1);
    localparam logic signed [WRAP_W-1:0] FULL_WRAP = WRAP_W'(FULL_TURN);
    localparam logic signed [WRAP_W-1:0] HALF_WRAP = WRAP_W'(HALF_TURN);

    localparam logic [DUR_W-1:0] DURATION_RESET = DUR_W'(150000);
    localparam logic [EPS_W-1:0] EPSILON_RESET  = EPS_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET      = 2'd0,
        CMD_SET_ROLL = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_TICK     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    function automatic logic [ANGLE_W-1:0] angle_mag(input logic signed [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] u;
        u = a;
        return u[ANGLE_W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic logic exceeds_eps(input logic signed [ANGLE_W-1:0] a,
                                         input logic [EPS_W-1:0] eps);
        return angle_mag(a) > ANGLE_W'(eps);
    endfunction

endpackage

`default_nettype wire

// ===== design/toqr_cfg_if.sv =====
`default_nettype none

interface toqr_cfg_if import toqr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DUR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/toqr_in_if.sv =====
`default_nettype none

interface toqr_in_if import toqr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [ANGLE_W-1:0] pitch_value;
    logic signed [ANGLE_W-1:0] yaw_value;
    logic signed [ANGLE_W-1:0] roll_value;
    logic signed [DELTA_W-1:0] delta_us;

    modport source (output valid, output command, output pitch_value, output yaw_value,
                    output roll_value, output delta_us, input ready);
    modport sink   (input valid, input command, input pitch_value, input yaw_value,
                    input roll_value, input delta_us, output ready);
endinterface

`default_nettype wire

// ===== design/toqr_out_if.sv =====
`default_nettype none

interface toqr_out_if import toqr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] view_pitch;
    logic signed [ANGLE_W-1:0] view_yaw;
    logic signed [ROLL_W-1:0]  view_roll;
    logic                      offset_active;
    logic                      release_running;

    modport source (output valid, output view_pitch, output view_yaw, output view_roll,
                    output offset_active, output release_running, input ready);
    modport sink   (input valid, input view_pitch, input view_yaw, input view_roll,
                    input offset_active, input release_running, output ready);
endinterface

`default_nettype wire

// ===== design/toqr_serial_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is at most the
// divisor, so the integer part is a single bit and the remainder stays below
// the divisor after the first step.
module toqr_serial_div import toqr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DUR_W-1:0] i_dividend,
    input  logic [DUR_W-1:0] i_divisor,
    output logic [Q_W-1:0]   o_quot,
    output t_unit_sts        o_sts
);

    localparam int CNT_W = $clog2(FALLOFF_FRAC_BITS + 1);

    logic [DUR_W:0]   r_rem;
    logic [DUR_W-1:0] r_divisor;
    logic [Q_W-1:0]   r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DUR_W:0] rem_shift;
    logic           step_ge;
    logic           first_ge;

    always_comb begin
        rem_shift = {r_rem[DUR_W-1:0], 1'b0};
        step_ge   = rem_shift >= {1'b0, r_divisor};
        first_ge  = i_dividend >= i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy    <= 1'b1;
                r_cnt     <= CNT_W'(FALLOFF_FRAC_BITS);
                r_divisor <= i_divisor;
                r_rem     <= first_ge ? {1'b0, i_dividend - i_divisor} : {1'b0, i_dividend};
                r_quot    <= {{FALLOFF_FRAC_BITS{1'b0}}, first_ge};
            end else if (r_busy) begin
                r_rem  <= step_ge ? rem_shift - {1'b0, r_divisor} : rem_shift;
                r_quot <= {r_quot[Q_W-2:0], step_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_quot;
    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;

endmodule

`default_nettype wire

// ===== design/toqr_serial_mul.sv =====
`default_nettype none

// Shift-add multiplier with one lane per axis. All lanes share the multiplier
// operand, which is shifted out of the low end of each accumulator one bit
// per cycle while the partial sum enters at the top.
module toqr_serial_mul import toqr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [Q_W-1:0]     i_mplier,
    input  logic [MCAND_W-1:0] i_mcand [N_AXES],
    output logic [PROD_W-1:0]  o_prod  [N_AXES],
    output t_unit_sts          o_sts
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [PROD_W-1:0]  r_acc   [N_AXES];
    logic [MCAND_W-1:0] r_mcand [N_AXES];
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [MCAND_W:0] n_hi [N_AXES];

    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            n_hi[i] = {1'b0, r_acc[i][PROD_W-1:Q_W]}
                    + (r_acc[i][0] ? {1'b0, r_mcand[i]} : {(MCAND_W + 1){1'b0}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
                for (int i = 0; i < N_AXES; i++) begin
                    r_acc[i]   <= {{MCAND_W{1'b0}}, i_mplier};
                    r_mcand[i] <= i_mcand[i];
                end
            end else if (r_busy) begin
                for (int i = 0; i < N_AXES; i++) begin
                    r_acc[i] <= {n_hi[i], r_acc[i][Q_W-1:1]};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod     = r_acc;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

`default_nettype wire

// ===== design/three_axis_offset_quadratic_release.sv =====
`default_nettype none
`include "three_axis_offset_quadratic_release_defines.svh"

// Three-axis view offset with quadratic release. Set, set-roll and clear
// beats are absorbed in the cycle they are accepted and give no result. A
// tick beat gives one result in the output register. With no release running
// it passes the sum and the pitch and yaw wrap folds; while a release runs it
// first passes the bit-serial alpha divider (F steps, F = FALLOFF_FRAC_BITS),
// then two passes through the shared shift-add multiplier (F + 1 steps each),
// one for the squared falloff and one scaling all three axes in parallel
// lanes.
// The input is accepted again once the result is in the output register; a
// finished result waits there without holding up set or clear beats.
// Configuration writes are always ready and take effect at once.
module three_axis_offset_quadratic_release import toqr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    toqr_cfg_if.sink    i_cfg,
    toqr_in_if.sink     i_in,
    toqr_out_if.source  o_out
);

    localparam int N_WRAP = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SQR_GO,
        S_SQR_WAIT,
        S_SCL_GO,
        S_SCL_WAIT,
        S_SUM,
        S_FOLD,
        S_OUT
    } t_state;

    t_state r_state;

    logic [DUR_W-1:0] r_duration;
    logic [EPS_W-1:0] r_epsilon;

    logic signed [ANGLE_W-1:0] r_target  [N_AXES];
    logic signed [ANGLE_W-1:0] r_applied [N_AXES];
    logic signed [ANGLE_W-1:0] r_start   [N_AXES];
    logic signed [ANGLE_W-1:0] r_view    [N_AXES];
    logic                      r_release;
    logic [DUR_W-1:0]          r_elapsed;

    logic [Q_W-1:0]           r_alpha;
    logic [Q_W-1:0]           r_falloff;
    logic signed [WRAP_W-1:0] r_sum [N_WRAP];
    logic signed [ROLL_W-1:0] r_roll_sum;
    logic                     r_active;
    logic [FOLD_CNT_W-1:0]    r_fold_cnt;

    logic                      r_out_valid;
    logic signed [ANGLE_W-1:0] r_out_pitch;
    logic signed [ANGLE_W-1:0] r_out_yaw;
    logic signed [ROLL_W-1:0]  r_out_roll;
    logic                      r_out_active;
    logic                      r_out_release;

    t_cmd                      cmd;
    logic                      in_fire;
    logic                      out_free;
    logic signed [ANGLE_W-1:0] n_target [N_AXES];
    logic                      targets_zero;
    logic                      any_applied;
    logic [DELTA_W-2:0]        delta_pos;
    logic [DUR_W:0]            e_sum;
    logic [DUR_W-1:0]          e_sat;
    logic [Q_W-1:0]            alpha_cap;
    logic [Q_W-1:0]            rem_alpha;
    logic [ANGLE_W-1:0]        scaled_mag [N_AXES];
    logic signed [ANGLE_W-1:0] scaled     [N_AXES];
    logic signed [WRAP_W-1:0]  n_fold [N_WRAP];
    logic signed [WRAP_W-1:0]  n_wrap [N_WRAP];

    logic               div_start;
    logic [Q_W-1:0]     div_quot;
    t_unit_sts          div_sts;
    logic               mul_start;
    logic [Q_W-1:0]     mul_mplier;
    logic [MCAND_W-1:0] mul_mcand [N_AXES];
    logic [PROD_W-1:0]  mul_prod  [N_AXES];
    t_unit_sts          mul_sts;

    assign cmd       = t_cmd'(i_in.command);
    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign div_start = (r_state == S_DIV_GO);
    assign mul_start = (r_state == S_SQR_GO) || (r_state == S_SCL_GO);

    always_comb begin
        // Set-roll keeps the stored pitch and yaw targets.
        n_target[0] = (cmd == CMD_SET) ? i_in.pitch_value : r_target[0];
        n_target[1] = (cmd == CMD_SET) ? i_in.yaw_value : r_target[1];
        n_target[2] = i_in.roll_value;

        targets_zero = 1'b1;
        any_applied  = 1'b0;
        for (int i = 0; i < N_AXES; i++) begin
            if (exceeds_eps(n_target[i], r_epsilon)) begin
                targets_zero = 1'b0;
            end
            if (exceeds_eps(r_applied[i], r_epsilon)) begin
                any_applied = 1'b1;
            end
        end

        delta_pos = i_in.delta_us[DELTA_W-1] ? '0 : i_in.delta_us[DELTA_W-2:0];
        e_sum     = {1'b0, r_elapsed} + (DUR_W + 1)'(delta_pos);
        e_sat     = (e_sum > {1'b0, r_duration}) ? r_duration : e_sum[DUR_W-1:0];

        // A zero duration makes the quotient all ones; it counts as one.
        alpha_cap = (div_quot > ALPHA_ONE) ? ALPHA_ONE : div_quot;
        rem_alpha = ALPHA_ONE - r_alpha;

        mul_mplier = (r_state == S_SQR_GO) ? rem_alpha : r_falloff;
        for (int i = 0; i < N_AXES; i++) begin
            mul_mcand[i]  = MCAND_W'(angle_mag(r_start[i]));
            scaled_mag[i] = mul_prod[i][FALLOFF_FRAC_BITS +: ANGLE_W];
            scaled[i]     = r_start[i][ANGLE_W-1] ? ANGLE_W'(~scaled_mag[i] + 1'b1)
                                                  : scaled_mag[i];
        end
        if (r_state == S_SQR_GO) begin
            mul_mcand[0] = MCAND_W'(rem_alpha);
        end

        for (int k = 0; k < N_WRAP; k++) begin
            if (r_sum[k] < 0) begin
                n_fold[k] = r_sum[k] + FULL_WRAP;
            end else if (r_sum[k] >= FULL_WRAP) begin
                n_fold[k] = r_sum[k] - FULL_WRAP;
            end else begin
                n_fold[k] = r_sum[k];
            end
            n_wrap[k] = (r_active && (r_sum[k] > HALF_WRAP)) ? r_sum[k] - FULL_WRAP
                                                              : r_sum[k];
        end
    end

    toqr_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_elapsed),
        .i_divisor  (r_duration),
        .o_quot     (div_quot),
        .o_sts      (div_sts)
    );

    toqr_serial_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mplier (mul_mplier),
        .i_mcand  (mul_mcand),
        .o_prod   (mul_prod),
        .o_sts    (mul_sts)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= DURATION_RESET;
            r_epsilon  <= EPSILON_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_DURATION: r_duration <= i_cfg.data;
                REG_EPSILON:  r_epsilon  <= i_cfg.data[EPS_W-1:0];
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_release   <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
            r_fold_cnt  <= '0;
            for (int i = 0; i < N_AXES; i++) begin
                r_target[i]  <= '0;
                r_applied[i] <= '0;
                r_start[i]   <= '0;
            end
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (cmd)
                            CMD_SET, CMD_SET_ROLL: begin
                                r_target <= n_target;
                                // Near-zero targets do not interrupt a release.
                                if (!(r_release && targets_zero)) begin
                                    r_release <= 1'b0;
                                    r_elapsed <= '0;
                                    r_applied <= n_target;
                                end
                            end
                            CMD_CLEAR: begin
                                for (int i = 0; i < N_AXES; i++) begin
                                    r_target[i] <= '0;
                                end
                                if (!any_applied) begin
                                    r_release <= 1'b0;
                                    r_elapsed <= '0;
                                    for (int i = 0; i < N_AXES; i++) begin
                                        r_applied[i] <= '0;
                                    end
                                end else if (!r_release) begin
                                    r_release <= 1'b1;
                                    r_elapsed <= '0;
                                    r_start   <= r_applied;
                                end
                            end
                            CMD_TICK: begin
                                r_view[0] <= i_in.pitch_value;
                                r_view[1] <= i_in.yaw_value;
                                r_view[2] <= i_in.roll_value;
                                if (r_release) begin
                                    r_elapsed <= e_sat;
                                    r_state   <= S_DIV_GO;
                                end else begin
                                    r_state <= S_SUM;
                                end
                            end
                        endcase
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_sts.done) begin
                        r_alpha <= alpha_cap;
                        r_state <= S_SQR_GO;
                    end
                end
                S_SQR_GO: begin
                    r_state <= S_SQR_WAIT;
                end
                S_SQR_WAIT: begin
                    if (mul_sts.done) begin
                        r_falloff <= mul_prod[0][FALLOFF_FRAC_BITS +: Q_W];
                        r_state   <= S_SCL_GO;
                    end
                end
                S_SCL_GO: begin
                    r_state <= S_SCL_WAIT;
                end
                S_SCL_WAIT: begin
                    if (mul_sts.done) begin
                        if (r_alpha == ALPHA_ONE) begin
                            r_release <= 1'b0;
                            r_elapsed <= '0;
                            for (int i = 0; i < N_AXES; i++) begin
                                r_applied[i] <= '0;
                            end
                        end else begin
                            r_applied <= scaled;
                        end
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_active   <= any_applied;
                    r_fold_cnt <= FOLD_CNT_W'(FOLDS);
                    for (int k = 0; k < N_WRAP; k++) begin
                        r_sum[k] <= any_applied ? WRAP_W'(r_view[k]) + WRAP_W'(r_applied[k])
                                                : WRAP_W'(r_view[k]);
                    end
                    r_roll_sum <= any_applied ? ROLL_W'(r_view[2]) + ROLL_W'(r_applied[2])
                                              : ROLL_W'(r_view[2]);
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    // Each pass brings pitch and yaw one turn closer to [0, full).
                    if (r_active) begin
                        r_sum <= n_fold;
                    end
                    r_fold_cnt <= r_fold_cnt - 1'b1;
                    if (r_fold_cnt == FOLD_CNT_W'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_pitch   <= n_wrap[0][ANGLE_W-1:0];
                        r_out_yaw     <= n_wrap[1][ANGLE_W-1:0];
                        r_out_roll    <= r_roll_sum;
                        r_out_active  <= r_active;
                        r_out_release <= r_release;
                        r_state       <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.view_pitch      = r_out_pitch;
    assign o_out.view_yaw        = r_out_yaw;
    assign o_out.view_roll       = r_out_roll;
    assign o_out.offset_active   = r_out_active;
    assign o_out.release_running = r_out_release;

    `TOQR_ASSERT(a_div_done_in_wait, i_clk, i_rst_n, div_sts.done |-> r_state == S_DIV_WAIT)
    `TOQR_ASSERT(a_mul_busy_in_wait, i_clk, i_rst_n, mul_sts.busy |-> (r_state == S_SQR_WAIT || r_state == S_SCL_WAIT))
    `TOQR_NEVER(a_units_exclusive, i_clk, i_rst_n, div_sts.busy && mul_sts.busy)
    `TOQR_ASSERT(a_elapsed_idle_zero, i_clk, i_rst_n, !r_release |-> r_elapsed == '0)
    `TOQR_ASSERT(a_result_from_out, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_OUT))

endmodule

`default_nettype wire
